FILE: sv/pbv_pkg.sv
// Package for the packed bit vector store: sizes, operation and status codes,
// sequencer states and the memory request bundle. No dependencies.
package pbv_pkg;

   localparam int CAPACITY_BYTES = 512;
   localparam int ADDR_W = $clog2(CAPACITY_BYTES);
   localparam int CAP_BITS = CAPACITY_BYTES * 8;

   localparam int MODE_W = 3;
   localparam int POS_W = 12;
   localparam int SPAN_W = 13;
   localparam int FIELD_W = 64;
   localparam int STATUS_W = 2;
   localparam int ACC_W = FIELD_W + 8;
   localparam int SHIFT_W = $clog2(ACC_W + 1);
   localparam int WIDE_W = SPAN_W + 1;

   localparam logic [MODE_W-1:0] MODE_INIT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GET = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SET = 3'd2;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;
   localparam logic [MODE_W-1:0] MODE_EXTRACT = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [7:0] BYTE_ONES = 8'hff;
   localparam logic [7:0] BYTE_TOP = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_WRITE,
      ST_FINISH,
      ST_WIPE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } mem_req_type;

endpackage

FILE: sv/pbv_if.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on pbv_pkg for field widths.
interface pbv_req_if import pbv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [POS_W-1:0]    position;
   logic [SPAN_W-1:0]   span;
   logic                bit_value;
   logic [FIELD_W-1:0]  bit_field;
   logic                reverse_order;

   modport source (output valid, mode, position, span, bit_value, bit_field,
                   reverse_order, input ready);
   modport sink (input valid, mode, position, span, bit_value, bit_field,
                 reverse_order, output ready);
endinterface

interface pbv_rsp_if import pbv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                bit_out;
   logic [SPAN_W-1:0]   tally;
   logic [FIELD_W-1:0]  field_out;
   logic [SPAN_W-1:0]   length_now;

   modport source (output valid, status, bit_out, tally, field_out, length_now,
                   input ready);
   modport sink (input valid, status, bit_out, tally, field_out, length_now,
                 output ready);
endinterface

FILE: sv/pbv_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pbv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: sv/pbv_engine.sv
// Sequencer and datapath: decodes a request, walks the bytes it touches in the
// byte store, merges or tallies them and builds the response. Uses pbv_pkg.
module pbv_engine import pbv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pbv_req_if.sink           req_chan,
   pbv_rsp_if.source         rsp_chan,
   output mem_req_type       mem_req,
   input  logic [7:0]        rd_data
);

   function automatic logic [FIELD_W-1:0] field_mask(input logic [SPAN_W-1:0] w);
      logic [FIELD_W-1:0] m;
      if (w >= SPAN_W'(FIELD_W)) begin
         m = '1;
      end else begin
         m = (FIELD_W'(1) << w[SHIFT_W-1:0]) - FIELD_W'(1);
      end
      return m;
   endfunction

   function automatic logic [FIELD_W-1:0] bit_reverse(input logic [FIELD_W-1:0] v);
      logic [FIELD_W-1:0] r;
      for (int i = 0; i < FIELD_W; i++) begin
         r[i] = v[FIELD_W-1-i];
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [MODE_W-1:0]   op_ff, op_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                go_read;
   logic                go_clear;
   logic [SPAN_W-1:0]   span_ff, span_in;
   logic                bval_ff, bval_in;
   logic                rev_ff, rev_in;
   logic [2:0]          off_ff, off_in;
   logic [2:0]          eoff_ff, eoff_in;
   logic [ADDR_W-1:0]   b0_ff, b0_in;
   logic [ADDR_W-1:0]   blast_ff, blast_in;
   logic [ADDR_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]   rem_ff, rem_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [ADDR_W-1:0]   wn_ff, wn_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                first_ff, first_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0]   rd_tag_ff, rd_tag_in;
   logic [7:0]          byte0_ff, byte0_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    wr_word_ff, wr_word_in;
   logic [SPAN_W-1:0]   ones_ff, ones_in;
   logic [SPAN_W-1:0]   length_ff, length_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_bit_ff, rsp_bit_in;
   logic [SPAN_W-1:0]   rsp_tally_ff, rsp_tally_in;
   logic [FIELD_W-1:0]  rsp_field_ff, rsp_field_in;
   logic [SPAN_W-1:0]   rsp_length_ff, rsp_length_in;

   logic accept;
   logic finish_load;
   logic clearing;
   logic [WIDE_W-1:0] pos_w, span_w, len_w, end_w, aend_w, cnt_last_w, app_last_w;
   logic [7:0] lo_mask, hi_mask, cnt_byte, set_byte;
   logic [3:0] pop;
   logic [ACC_W-1:0] ext_shifted;
   logic [FIELD_W-1:0] ext_val, ext_rev;

   assign accept = req_chan.valid && req_chan.ready;
   assign finish_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign clearing = (state_ff == ST_WIPE) || (state_ff == ST_CLEAR);
   assign clr_in = clearing ? clr_ff + ADDR_W'(1) : clr_ff;

   assign pos_w = WIDE_W'(req_chan.position);
   assign span_w = WIDE_W'(req_chan.span);
   assign len_w = WIDE_W'(length_ff);
   assign end_w = pos_w + span_w;
   assign aend_w = len_w + span_w;
   assign cnt_last_w = end_w - WIDE_W'(1);
   assign app_last_w = aend_w - WIDE_W'(1);

   // Request decode: status, byte range and read count.
   always_comb begin
      status_in = STATUS_OK;
      go_read = 1'b0;
      go_clear = 1'b0;
      off_in = req_chan.position[2:0];
      eoff_in = cnt_last_w[2:0];
      b0_in = ADDR_W'(pos_w >> 3);
      blast_in = ADDR_W'(cnt_last_w >> 3);
      rem_in = '0;
      wn_in = '0;
      case (req_chan.mode)
         MODE_INIT: begin
            if (req_chan.span > SPAN_W'(CAP_BITS)) begin
               status_in = STATUS_FULL;
            end else begin
               go_clear = 1'b1;
            end
         end
         MODE_GET, MODE_SET: begin
            if (WIDE_W'(req_chan.position) >= len_w) begin
               status_in = STATUS_RANGE;
            end else begin
               go_read = 1'b1;
            end
         end
         MODE_APPEND: begin
            off_in = length_ff[2:0];
            b0_in = ADDR_W'(len_w >> 3);
            wn_in = ADDR_W'((app_last_w >> 3) - (len_w >> 3));
            if (req_chan.span > SPAN_W'(FIELD_W)) begin
               status_in = STATUS_RANGE;
            end else if (aend_w > WIDE_W'(CAP_BITS)) begin
               status_in = STATUS_FULL;
            end else if (req_chan.span != '0) begin
               go_read = 1'b1;
            end
         end
         MODE_COUNT: begin
            rem_in = ADDR_W'((cnt_last_w >> 3) - (pos_w >> 3));
            if (req_chan.span == '0) begin
               status_in = STATUS_OK;
            end else if (end_w > len_w) begin
               status_in = STATUS_RANGE;
            end else begin
               go_read = 1'b1;
            end
         end
         MODE_EXTRACT: begin
            rem_in = ADDR_W'(8);
            if (req_chan.span > SPAN_W'(FIELD_W) || end_w > len_w) begin
               status_in = STATUS_RANGE;
            end else if (req_chan.span != '0) begin
               go_read = 1'b1;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (go_clear) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = go_read ? ST_READ : ST_FINISH;
               end
            end
         end
         ST_READ: begin
            if (rem_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (op_ff == MODE_APPEND || op_ff == MODE_SET) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WRITE: begin
            if (wn_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_WIPE: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_FINISH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign set_byte = bval_ff ? (byte0_ff | (BYTE_TOP >> off_ff))
                             : (byte0_ff & ~(BYTE_TOP >> off_ff));

   // Outputs of the sequencer: handshake and memory requests.
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      mem_req.rd_en = (state_ff == ST_READ);
      mem_req.rd_addr = rd_addr_ff;
      mem_req.wr_en = (state_ff == ST_WRITE) || clearing;
      mem_req.wr_addr = clearing ? clr_ff : wr_addr_ff;
      if (clearing) begin
         mem_req.wr_data = '0;
      end else if (op_ff == MODE_SET) begin
         mem_req.wr_data = set_byte;
      end else if (first_ff) begin
         mem_req.wr_data = (byte0_ff & ~(BYTE_ONES >> off_ff)) | wr_word_ff[ACC_W-1 -: 8];
      end else begin
         mem_req.wr_data = wr_word_ff[ACC_W-1 -: 8];
      end
   end

   // Tally of one byte of a count range.
   always_comb begin
      lo_mask = (rd_tag_ff == b0_ff) ? (BYTE_ONES >> off_ff) : BYTE_ONES;
      hi_mask = (rd_tag_ff == blast_ff) ? (BYTE_ONES << (3'd7 - eoff_ff)) : BYTE_ONES;
      cnt_byte = rd_data & lo_mask & hi_mask;
      pop = '0;
      for (int i = 0; i < 8; i++) begin
         pop = pop + 4'(cnt_byte[i]);
      end
   end

   assign ext_shifted = acc_ff >> (SHIFT_W'(ACC_W) - SHIFT_W'(off_ff) - span_ff[SHIFT_W-1:0]);
   assign ext_val = FIELD_W'(ext_shifted) & field_mask(span_ff);
   assign ext_rev = bit_reverse(ext_val) >> (SHIFT_W'(FIELD_W) - span_ff[SHIFT_W-1:0]);

   // Datapath next values.
   always_comb begin
      op_in = op_ff;
      span_in = span_ff;
      bval_in = bval_ff;
      rev_in = rev_ff;
      rd_addr_in = rd_addr_ff;
      wr_addr_in = wr_addr_ff;
      first_in = first_ff;
      byte0_in = byte0_ff;
      acc_in = acc_ff;
      wr_word_in = wr_word_ff;
      ones_in = ones_ff;
      length_in = length_ff;
      rd_pend_in = (state_ff == ST_READ);
      rd_tag_in = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_bit_in = rsp_bit_ff;
      rsp_tally_in = rsp_tally_ff;
      rsp_field_in = rsp_field_ff;
      rsp_length_in = rsp_length_ff;

      if (accept) begin
         op_in = req_chan.mode;
         span_in = req_chan.span;
         bval_in = req_chan.bit_value;
         rev_in = req_chan.reverse_order;
         rd_addr_in = b0_in;
         wr_addr_in = b0_in;
         first_in = 1'b1;
         ones_in = '0;
         wr_word_in = ACC_W'(req_chan.bit_field & field_mask(req_chan.span))
                      << (SHIFT_W'(ACC_W) - SHIFT_W'(off_in)
                          - req_chan.span[SHIFT_W-1:0]);
      end

      if (state_ff == ST_READ) begin
         rd_addr_in = rd_addr_ff + ADDR_W'(1);
      end

      if (rd_pend_ff) begin
         byte0_in = rd_data;
         acc_in = {acc_ff[ACC_W-9:0], rd_data};
         ones_in = ones_ff + SPAN_W'(pop);
      end

      if (state_ff == ST_WRITE) begin
         wr_addr_in = wr_addr_ff + ADDR_W'(1);
         first_in = 1'b0;
         wr_word_in = wr_word_ff << 8;
      end

      if (finish_load) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = status_ff;
         rsp_bit_in = 1'b0;
         rsp_tally_in = '0;
         rsp_field_in = '0;
         if (status_ff == STATUS_OK) begin
            case (op_ff)
               MODE_INIT: length_in = span_ff;
               MODE_APPEND: length_in = length_ff + span_ff;
               MODE_GET: rsp_bit_in = byte0_ff[~off_ff];
               MODE_COUNT: rsp_tally_in = bval_ff ? ones_ff : span_ff - ones_ff;
               MODE_EXTRACT: rsp_field_in = rev_ff ? ext_rev : ext_val;
               default: rsp_bit_in = 1'b0;
            endcase
         end
         rsp_length_in = length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         length_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         length_ff <= length_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         off_ff <= off_in;
         eoff_ff <= eoff_in;
         b0_ff <= b0_in;
         blast_ff <= blast_in;
      end
      if (accept) begin
         rem_ff <= rem_in;
         wn_ff <= wn_in;
      end else begin
         if (state_ff == ST_READ && rem_ff != '0) begin
            rem_ff <= rem_ff - ADDR_W'(1);
         end
         if (state_ff == ST_WRITE && wn_ff != '0) begin
            wn_ff <= wn_ff - ADDR_W'(1);
         end
      end
      op_ff <= op_in;
      span_ff <= span_in;
      bval_ff <= bval_in;
      rev_ff <= rev_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      first_ff <= first_in;
      rd_tag_ff <= rd_tag_in;
      byte0_ff <= byte0_in;
      acc_ff <= acc_in;
      wr_word_ff <= wr_word_in;
      ones_ff <= ones_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bit_ff <= rsp_bit_in;
      rsp_tally_ff <= rsp_tally_in;
      rsp_field_ff <= rsp_field_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.bit_out = rsp_bit_ff;
   assign rsp_chan.tally = rsp_tally_ff;
   assign rsp_chan.field_out = rsp_field_ff;
   assign rsp_chan.length_now = rsp_length_ff;

endmodule

FILE: sv/packed_bit_vector_store_top.sv
// Top level of the packed bit vector store: sequencer plus byte store RAM.
// Depends on pbv_pkg, pbv_if, pbv_ram and pbv_engine.
//
//   Channel    Direction  Transaction
//   req_chan   in         mode, position, span, bit_value, bit_field, reverse_order
//   rsp_chan   out        status, bit_out, tally, field_out, length_now
//
// Get reads one byte, set also writes it back, append writes one byte per cycle,
// extract makes nine byte reads, count reads each byte of its range, and init
// makes a pass that clears the store; errors and empty operations skip the store.
// The store has a single RAM port pair and moves one byte per cycle.
// Reset clears the length and then all 512 bytes of the store, with input not ready.
// A new transaction is taken while the previous response waits to be taken.
module packed_bit_vector_store_top import pbv_pkg::*; (
   input logic        clock,
   input logic        reset,
   pbv_req_if.sink    req_chan,
   pbv_rsp_if.source  rsp_chan
);

   mem_req_type mem_req;
   logic [7:0]  rd_data;

   pbv_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   pbv_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

endmodule
